>>> hw/rtl/sct_pkg.sv
// Shared types, codes and keyword tables for the small C tokenizer.
`default_nettype none
package sct_pkg;

  localparam int DEF_OFFSET_BITS = 16;
  localparam int DEF_LINE_BITS   = 16;

  localparam int TOKQ_DEPTH = 4;
  localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);
  localparam int TOKQ_CW    = $clog2(TOKQ_DEPTH + 1);

  typedef enum logic [4:0] {
    TK_EOF    = 5'd0,
    TK_IDENT  = 5'd1,
    TK_NUMBER = 5'd2,
    TK_IF     = 5'd3,
    TK_INT    = 5'd4,
    TK_WHILE  = 5'd5,
    TK_RETURN = 5'd6,
    TK_PLUS   = 5'd7,
    TK_MINUS  = 5'd8,
    TK_STAR   = 5'd9,
    TK_SLASH  = 5'd10,
    TK_ASSIGN = 5'd11,
    TK_EQ     = 5'd12,
    TK_NEQ    = 5'd13,
    TK_LT     = 5'd14,
    TK_LE     = 5'd15,
    TK_GT     = 5'd16,
    TK_GE     = 5'd17,
    TK_LPAREN = 5'd18,
    TK_RPAREN = 5'd19,
    TK_LBRACE = 5'd20,
    TK_RBRACE = 5'd21,
    TK_SEMI   = 5'd22
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_EQ    = 3'd3,
    MODE_LT    = 3'd4,
    MODE_GT    = 3'd5,
    MODE_BANG  = 3'd6
  } scan_mode_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [15:0]        start;
    logic [15:0]        length;
    logic [15:0]        line;
    logic signed [31:0] value;
    logic               last;
  } tok_t;

  typedef struct packed {
    logic a_vld;
    logic b_vld;
  } push_t;

  // keyword text, zero padded to 8 characters
  localparam logic [7:0] KW_TEXT [4][8] = '{
    '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"i", "n", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0},
    '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0}
  };
  localparam logic [2:0] KW_LEN [4] = '{3'd2, 3'd3, 3'd5, 3'd6};
  localparam tok_kind_t KW_KIND [4] = '{TK_IF, TK_INT, TK_WHILE, TK_RETURN};

endpackage
`default_nettype wire

>>> hw/rtl/sct_char_if.sv
// Character input channel: one source byte per word.
`default_nettype none
interface sct_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sct_token_if.sv
// Token output channel: one token per word.
`default_nettype none
interface sct_token_if;
  logic               valid;
  logic               ready;
  logic [4:0]         token_kind;
  logic [15:0]        token_start;
  logic [15:0]        token_length;
  logic [15:0]        token_line;
  logic signed [31:0] number_value;
  logic               last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output number_value, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input token_line, input number_value, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sct_tok_fifo.sv
// Token queue: takes up to two tokens per cycle, gives one per ready cycle.
`default_nettype none
module sct_tok_fifo
  import sct_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire push_t  push,
  input  wire tok_t   tok_a,
  input  wire tok_t   tok_b,
  output logic        room,
  sct_token_if.source tokens
);

  tok_t                mem [TOKQ_DEPTH];
  logic [TOKQ_AW-1:0]  wr_ptr;
  logic [TOKQ_AW-1:0]  rd_ptr;
  logic [TOKQ_CW-1:0]  count;
  logic [TOKQ_CW-1:0]  count_next;
  logic [TOKQ_AW-1:0]  wr_ptr_next;
  logic                pop;
  logic [TOKQ_CW-1:0]  n_push;
  tok_t                head;

  assign pop    = tokens.valid && tokens.ready;
  assign n_push = TOKQ_CW'(push.a_vld) + TOKQ_CW'(push.b_vld);
  assign room   = (count - TOKQ_CW'(pop)) <= TOKQ_CW'(TOKQ_DEPTH - 2);

  assign count_next  = count + n_push - TOKQ_CW'(pop);
  assign wr_ptr_next = wr_ptr + n_push[TOKQ_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.a_vld) begin
      mem[wr_ptr] <= tok_a;
    end
    if (push.b_vld) begin
      mem[wr_ptr + 1'b1] <= tok_b;
    end
  end

  assign head                = mem[rd_ptr];
  assign tokens.valid        = count != '0;
  assign tokens.token_kind   = head.kind;
  assign tokens.token_start  = head.start;
  assign tokens.token_length = head.length;
  assign tokens.token_line   = head.line;
  assign tokens.number_value = head.value;
  assign tokens.last_of_run  = head.last;

endmodule
`default_nettype wire

>>> hw/rtl/small_c_tokenizer.sv
// Small C tokenizer top level: character register, scanner state, token queue.
// Usage:
//   chars  : one source byte per word (valid/ready). Byte 0 ends the source.
//   tokens : one token per word: kind, start offset, length, line, value of a
//            number, and last_of_run on the final token a byte produced.
//   A byte produces zero, one or two tokens. Whitespace, a lone '!' and
//   unknown bytes produce none; a byte that closes a pending word, number or
//   '=', '<', '>' can produce two.
// Flow: a byte is registered in ch_q, scanned from that register and its
//   tokens are written into a 4-entry queue; the first token is presented at
//   the queue head, where the receiver takes it.
// Throughput: one byte per cycle while the queue has room. Output runs at one
//   token per cycle while ready is high, so bytes that produce two tokens
//   outrun the output; the queue absorbs that.
// Stall: when the receiver holds ready low the queue fills and chars.ready
//   drops once fewer than two entries are free; nothing is lost.
// Reset: synchronous, clears the queue and scanner state (offset 0, line 1).
//   Byte 0 emits any pending token, then EOF, and returns to that state.
`default_nettype none
module small_c_tokenizer
  import sct_pkg::*;
#(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int LINE_BITS   = DEF_LINE_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sct_char_if.sink    chars,
  sct_token_if.source tokens
);

  logic [7:0]             ch_q;
  logic                   ch_vld;
  logic                   room;
  logic                   adv;

  scan_mode_t             mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [OFFSET_BITS-1:0] pstart, pstart_next;
  logic [31:0]            acc, acc_next;
  logic [3:0]             cand, cand_next;
  logic [15:0]            wl, wl_next;

  logic                   is_dig, is_alp, is_wrd, used;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [15:0]            wl_inc;
  logic [3:0]             cand_nar, cand_first;
  tok_kind_t              wkind;
  logic [OFFSET_BITS+15:0] pos_w, pstart_w, eof_w;
  logic [LINE_BITS+15:0]  line_w;
  logic [15:0]            pos16, pstart16, eof16, line16;
  logic [31:0]            digit;
  tok_t                   pend, own;
  logic                   pend_vld, own_vld;
  push_t                  push;
  tok_t                   tok_a, tok_b;

  assign adv         = ch_vld && room;
  assign chars.ready = !ch_vld || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_vld <= 1'b0;
    end else if (chars.ready) begin
      ch_vld <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      ch_q <= chars.ch;
    end
  end

  always_comb begin
    is_dig  = ch_q >= "0" && ch_q <= "9";
    is_alp  = (ch_q >= "a" && ch_q <= "z") || (ch_q >= "A" && ch_q <= "Z");
    is_wrd  = is_dig || is_alp || ch_q == "_";
    digit   = {24'd0, ch_q - 8'h30};
    pos_inc = (pos == '1) ? pos : pos + 1'b1;
    wl_inc  = (wl == 16'hFFFF) ? wl : wl + 16'd1;

    for (int k = 0; k < 4; k++) begin
      cand_nar[k]   = cand[k] && (wl < 16'(KW_LEN[k])) && (KW_TEXT[k][wl[2:0]] == ch_q);
      cand_first[k] = KW_TEXT[k][0] == ch_q;
    end
    wkind = TK_IDENT;
    for (int k = 0; k < 4; k++) begin
      if (cand[k] && wl == 16'(KW_LEN[k])) begin
        wkind = KW_KIND[k];
      end
    end

    pos_w    = {16'd0, pos};
    pstart_w = {16'd0, pstart};
    eof_w    = {16'd0, pos_inc};
    line_w   = {16'd0, line};
    pos16    = pos_w[15:0];
    pstart16 = pstart_w[15:0];
    eof16    = eof_w[15:0];
    line16   = line_w[15:0];
  end

  // scanner step
  always_comb begin
    mode_next   = mode;
    pos_next    = pos_inc;
    line_next   = line;
    pstart_next = pstart;
    acc_next    = acc;
    cand_next   = cand;
    wl_next     = wl;
    used        = 1'b0;
    pend_vld    = 1'b0;
    own_vld     = 1'b0;
    pend        = '{kind: TK_EOF, start: pstart16, length: wl, line: line16, value: '0,
                    last: 1'b0};
    own         = '{kind: TK_EOF, start: pos16, length: 16'd1, line: line16, value: '0,
                    last: 1'b0};

    unique case (mode)
      MODE_IDENT: begin
        if (is_wrd) begin
          cand_next = cand_nar;
          wl_next   = wl_inc;
          used      = 1'b1;
        end else begin
          pend_vld  = 1'b1;
          pend.kind = wkind;
        end
      end
      MODE_NUM: begin
        if (is_dig) begin
          acc_next = (acc << 3) + (acc << 1) + digit;
          wl_next  = wl_inc;
          used     = 1'b1;
        end else begin
          pend_vld   = 1'b1;
          pend.kind  = TK_NUMBER;
          pend.value = acc;
        end
      end
      MODE_EQ, MODE_LT, MODE_GT, MODE_BANG: begin
        if (ch_q == "=") begin
          used        = 1'b1;
          pend_vld    = 1'b1;
          pend.length = 16'd2;
          unique case (mode)
            MODE_EQ: pend.kind = TK_EQ;
            MODE_LT: pend.kind = TK_LE;
            MODE_GT: pend.kind = TK_GE;
            default: pend.kind = TK_NEQ;
          endcase
        end else if (mode != MODE_BANG) begin
          pend_vld    = 1'b1;
          pend.length = 16'd1;
          unique case (mode)
            MODE_EQ: pend.kind = TK_ASSIGN;
            MODE_LT: pend.kind = TK_LT;
            default: pend.kind = TK_GT;
          endcase
        end
      end
      default: ;
    endcase

    if (!used || mode == MODE_EQ || mode == MODE_LT || mode == MODE_GT ||
        mode == MODE_BANG) begin
      mode_next = MODE_IDLE;
    end

    if (!used) begin
      case (ch_q)
        8'd0: begin
          own_vld     = 1'b1;
          own.kind    = TK_EOF;
          own.start   = eof16;
          own.length  = 16'd0;
          mode_next   = MODE_IDLE;
          pos_next    = '0;
          line_next   = LINE_BITS'(1);
          pstart_next = '0;
          acc_next    = '0;
          cand_next   = 4'hF;
          wl_next     = '0;
        end
        8'h0A: begin
          if (line != '1) begin
            line_next = line + 1'b1;
          end
        end
        "+": begin own_vld = 1'b1; own.kind = TK_PLUS; end
        "-": begin own_vld = 1'b1; own.kind = TK_MINUS; end
        "*": begin own_vld = 1'b1; own.kind = TK_STAR; end
        "/": begin own_vld = 1'b1; own.kind = TK_SLASH; end
        "(": begin own_vld = 1'b1; own.kind = TK_LPAREN; end
        ")": begin own_vld = 1'b1; own.kind = TK_RPAREN; end
        "{": begin own_vld = 1'b1; own.kind = TK_LBRACE; end
        "}": begin own_vld = 1'b1; own.kind = TK_RBRACE; end
        ";": begin own_vld = 1'b1; own.kind = TK_SEMI; end
        "=": begin mode_next = MODE_EQ; pstart_next = pos; end
        "<": begin mode_next = MODE_LT; pstart_next = pos; end
        ">": begin mode_next = MODE_GT; pstart_next = pos; end
        "!": begin mode_next = MODE_BANG; pstart_next = pos; end
        default: begin
          if (is_dig) begin
            mode_next   = MODE_NUM;
            pstart_next = pos;
            acc_next    = digit;
            wl_next     = 16'd1;
          end else if (is_alp) begin
            mode_next   = MODE_IDENT;
            pstart_next = pos;
            cand_next   = cand_first;
            wl_next     = 16'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      line   <= LINE_BITS'(1);
      pstart <= '0;
      acc    <= '0;
      cand   <= 4'hF;
      wl     <= '0;
    end else if (adv) begin
      mode   <= mode_next;
      pos    <= pos_next;
      line   <= line_next;
      pstart <= pstart_next;
      acc    <= acc_next;
      cand   <= cand_next;
      wl     <= wl_next;
    end
  end

  // pack pending token first, then the byte's own token
  always_comb begin
    push.a_vld = adv && (pend_vld || own_vld);
    push.b_vld = adv && pend_vld && own_vld;
    tok_a      = pend_vld ? pend : own;
    tok_a.last = !(pend_vld && own_vld);
    tok_b      = own;
    tok_b.last = 1'b1;
  end

  sct_tok_fifo u_tokq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .tok_a  (tok_a),
    .tok_b  (tok_b),
    .room   (room),
    .tokens (tokens)
  );

endmodule
`default_nettype wire

>>> hw/rtl/sct_checker.sv
// Port-level checks for the small C tokenizer, bound to the top level.
`default_nettype none
module sct_checker
  import sct_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tok_valid,
  input wire logic        tok_ready,
  input wire logic [4:0]  tok_kind,
  input wire logic [15:0] tok_length,
  input wire logic [15:0] tok_line,
  input wire logic [31:0] tok_value,
  input wire logic        tok_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token output valid right after reset");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind == TK_EOF |-> tok_length == 16'd0 && tok_value == 32'd0 && tok_last)
    else $error("malformed EOF token");

  a_value_only_numbers: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind != TK_NUMBER |-> tok_value == 32'd0)
    else $error("non-number token carries a value");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind != TK_EOF |-> tok_line != 16'd0 && tok_length != 16'd0)
    else $error("token with zero line or zero length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_last))
    else $error("stalled token changed");

endmodule

bind small_c_tokenizer sct_checker u_sct_checker (
  .clk        (clk),
  .rst        (rst),
  .tok_valid  (tokens.valid),
  .tok_ready  (tokens.ready),
  .tok_kind   (tokens.token_kind),
  .tok_length (tokens.token_length),
  .tok_line   (tokens.token_line),
  .tok_value  (tokens.number_value),
  .tok_last   (tokens.last_of_run)
);
`default_nettype wire
